// ----- src/tfcm_pkg.sv -----
// Shared types, constants and palette functions for the thermal false-colour mapper.
`timescale 1ns / 1ps
`default_nettype none
package tfcm_pkg;

	// image geometry (row-major pixel index)
	localparam int IMG_W = 12;

	// temperature and divider widths
	localparam int TEMP_W  = 16;
	localparam int FRAC_W  = 8;
	localparam int STOP_W  = 3;
	localparam int QW      = STOP_W + FRAC_W;   // quotient bits: stop index and fraction
	localparam int T3_W    = TEMP_W + 2;        // 3 * t
	localparam int NUM_W   = T3_W + 9;          // 3 * t * 512 = 6 * t * 256

	// depth of the queue between front and back
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	// palette
	localparam logic [STOP_W-1:0] STOP_FIRST = 3'd0;
	localparam logic [STOP_W-1:0] STOP_LAST  = 3'd6;

	// register indexes of the config port
	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	// sample class decided by the front
	localparam logic [1:0] CLS_LOW  = 2'd0;   // at or below low, or empty range
	localparam logic [1:0] CLS_HIGH = 2'd1;   // at or above high
	localparam logic [1:0] CLS_MID  = 2'd2;   // strictly inside, interpolate

	typedef struct packed {
		logic [1:0]        cls;
		logic [TEMP_W-1:0] dvs;   // high - low, valid for CLS_MID
		logic [T3_W-1:0]   t3;    // 3 * (temperature - low), valid for CLS_MID
		logic [7:0]        pix;
	} fq_item_t;

	// stop colors in halves: {r, g, b}, 2 = full, 1 = half
	function automatic logic [5:0] stop_halves(input logic [STOP_W-1:0] idx);
		logic [5:0] h;
		case (idx)
			3'd0:    h = {2'd0, 2'd0, 2'd2};
			3'd1:    h = {2'd0, 2'd2, 2'd2};
			3'd2:    h = {2'd0, 2'd2, 2'd0};
			3'd3:    h = {2'd2, 2'd2, 2'd0};
			3'd4:    h = {2'd2, 2'd1, 2'd0};
			3'd5:    h = {2'd2, 2'd0, 2'd0};
			3'd6:    h = {2'd2, 2'd0, 2'd2};
			default: h = {2'd0, 2'd0, 2'd2};
		endcase
		return h;
	endfunction

	// floor((h1*256 + (h2-h1)*f) * 255 / 512); the sum never goes negative
	function automatic logic [7:0] chan_val(input logic [1:0] h1, input logic [1:0] h2,
			input logic [FRAC_W-1:0] f);
		logic signed [2:0]  dh;
		logic signed [11:0] num;
		logic [17:0]        scl;
		dh  = signed'({1'b0, h2}) - signed'({1'b0, h1});
		num = signed'({2'b00, h1, 8'h00}) + dh * signed'({4'h0, f});
		scl = {num[9:0], 8'h00} - {8'h00, num[9:0]};
		return scl[16:9];
	endfunction

endpackage
`default_nettype wire

// ----- src/thermal_false_colour_map.sv -----
// Top level of the thermal false-colour mapper: config registers, front, queue, back.
//
//  channel   transfer when        payload
//  -------   -----------------    ------------------------------------
//  input     push  && !full       temperature, column, row
//  result    pop   && !empty      pixel_index, red, green, blue
//  config    cfg_we               cfg_index, cfg_data
//
// One sample per clock is sustained while results are taken; a sample passes
// from its input transfer to its result through the front register, the queue,
// the divider's input register, 11 divider stages that yield the stop index
// and fraction, and the output register.
// Reset clears all valids, the queue pointers and loads the default range.
// A stalled result stops the back pipeline; the 4-entry queue and front stage
// keep taking samples until they fill, then full rises.
`timescale 1ns / 1ps
`default_nettype none
module thermal_false_colour_map (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [tfcm_pkg::TEMP_W-1:0] temperature,
	input  wire logic [3:0]                  column,
	input  wire logic [3:0]                  row,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [7:0]                       pixel_index,
	output logic [7:0]                       red,
	output logic [7:0]                       green,
	output logic [7:0]                       blue,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [tfcm_pkg::TEMP_W-1:0] cfg_data
);
	import tfcm_pkg::*;

	logic [TEMP_W-1:0] low_q;
	logic [TEMP_W-1:0] high_q;
	logic              fq_push;
	logic              fq_full;
	logic              fq_pop;
	logic              fq_empty;
	fq_item_t          fq_in;
	fq_item_t          fq_head;

	// range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= TEMP_W'(320);
			high_q <= TEMP_W'(3200);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tfcm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.temperature (temperature),
		.column      (column),
		.row         (row),
		.low_temp    (low_q),
		.high_temp   (high_q),
		.fq_push     (fq_push),
		.fq_full     (fq_full),
		.fq_item     (fq_in)
	);

	tfcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fq_push),
		.push_item (fq_in),
		.full      (fq_full),
		.pop       (fq_pop),
		.empty     (fq_empty),
		.head_item (fq_head)
	);

	tfcm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_avail    (!fq_empty),
		.in_item     (fq_head),
		.in_pop      (fq_pop),
		.pop         (pop),
		.empty       (empty),
		.pixel_index (pixel_index),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	// queue is never pushed when full nor popped when empty
	a_fq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(fq_push && fq_full))
		else $error("queue pushed while full");

	a_fq_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(fq_pop && fq_empty))
		else $error("queue popped while empty");

	// a waiting result is not dropped by the back pipeline
	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result lost without transfer");

endmodule
`default_nettype wire

// ----- src/tfcm_front.sv -----
// Front stage: classifies a sample against the range, forms the divider operands and the pixel index.
`timescale 1ns / 1ps
`default_nettype none
module tfcm_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [tfcm_pkg::TEMP_W-1:0]   temperature,
	input  wire logic [3:0]                    column,
	input  wire logic [3:0]                    row,
	input  wire logic [tfcm_pkg::TEMP_W-1:0]   low_temp,
	input  wire logic [tfcm_pkg::TEMP_W-1:0]   high_temp,
	output logic                               fq_push,
	input  wire logic                          fq_full,
	output tfcm_pkg::fq_item_t                 fq_item
);
	import tfcm_pkg::*;

	logic signed [TEMP_W:0] d_c;
	logic signed [TEMP_W:0] t_c;
	logic [11:0]            prod_c;
	fq_item_t               item_c;
	fq_item_t               item_s1;
	logic                   vld_s1;

	// range and offset, one bit wider to hold any difference
	always_comb begin
		d_c = signed'({high_temp[TEMP_W-1], high_temp}) - signed'({low_temp[TEMP_W-1], low_temp});
		t_c = signed'({temperature[TEMP_W-1], temperature})
			- signed'({low_temp[TEMP_W-1], low_temp});
		prod_c = {8'h00, row} * 12'(IMG_W);
		item_c.pix = prod_c[7:0] + {4'h0, column};
		item_c.dvs = d_c[TEMP_W-1:0];
		item_c.t3  = {2'b00, t_c[TEMP_W-1:0]} + {1'b0, t_c[TEMP_W-1:0], 1'b0};
		if (d_c <= 0 || t_c <= 0) begin
			item_c.cls = CLS_LOW;
		end else if (t_c >= d_c) begin
			item_c.cls = CLS_HIGH;
		end else begin
			item_c.cls = CLS_MID;
		end
	end

	// one register stage, held while it holds a sample and the queue is full
	assign full    = vld_s1 && fq_full;
	assign fq_push = vld_s1 && !fq_full;
	assign fq_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!full) begin
			vld_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_s1 <= item_c;
		end
	end

endmodule
`default_nettype wire

// ----- src/tfcm_queue.sv -----
// Short FIFO that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none
module tfcm_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire tfcm_pkg::fq_item_t push_item,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output tfcm_pkg::fq_item_t head_item
);
	import tfcm_pkg::*;

	fq_item_t         slot_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q;
	logic [FQ_AW-1:0] rd_ptr_q;
	logic [FQ_AW:0]   count_q;

	assign full      = (count_q == (FQ_AW+1)'(FQ_DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ----- src/tfcm_back.sv -----
// Back end: pipelined restoring divider for stop and fraction, then palette blend.
`timescale 1ns / 1ps
`default_nettype none
module tfcm_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_avail,
	input  wire tfcm_pkg::fq_item_t in_item,
	output logic                    in_pop,
	input  wire logic               pop,
	output logic                    empty,
	output logic [7:0]              pixel_index,
	output logic [7:0]              red,
	output logic [7:0]              green,
	output logic [7:0]              blue
);
	import tfcm_pkg::*;

	// pipeline stage j holds the remainder after j quotient bits
	logic              vld_s  [QW+1];
	logic [1:0]        cls_s  [QW+1];
	logic [TEMP_W-1:0] dvs_s  [QW+1];
	logic [NUM_W-1:0]  rem_s  [QW+1];
	logic [QW-1:0]     quo_s  [QW+1];
	logic [7:0]        pix_s  [QW+1];

	logic [NUM_W-1:0]  rem_nx [QW];
	logic [QW-1:0]     quo_nx [QW];

	logic              out_vld_q;
	logic [7:0]        pix_q;
	logic [7:0]        red_q;
	logic [7:0]        grn_q;
	logic [7:0]        blu_q;

	logic              adv;
	logic [STOP_W-1:0] i1_c;
	logic [STOP_W-1:0] i2_c;
	logic [FRAC_W-1:0] f_c;
	logic [5:0]        h1_c;
	logic [5:0]        h2_c;

	// whole pipeline moves when the output register is free or being drained
	assign adv    = !out_vld_q || pop;
	assign in_pop = adv && in_avail;

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [NUM_W-1:0] dsh;
		always_comb begin
			dsh = NUM_W'(dvs_s[j]) << K;
			rem_nx[j] = rem_s[j];
			quo_nx[j] = quo_s[j];
			if (rem_s[j] >= dsh) begin
				rem_nx[j] = rem_s[j] - dsh;
				quo_nx[j][K] = 1'b1;
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= QW; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= in_avail;
			for (int j = 0; j < QW; j++) begin
				vld_s[j+1] <= vld_s[j];
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s[0] <= in_item.cls;
			dvs_s[0] <= in_item.dvs;
			rem_s[0] <= {in_item.t3, 9'h000};
			quo_s[0] <= '0;
			pix_s[0] <= in_item.pix;
			for (int j = 0; j < QW; j++) begin
				cls_s[j+1] <= cls_s[j];
				dvs_s[j+1] <= dvs_s[j];
				rem_s[j+1] <= rem_nx[j];
				quo_s[j+1] <= quo_nx[j];
				pix_s[j+1] <= pix_s[j];
			end
		end
	end

	// pick the neighbouring stops and the fraction
	always_comb begin
		case (cls_s[QW])
			CLS_MID: begin
				i1_c = quo_s[QW][QW-1:FRAC_W];
				i2_c = quo_s[QW][QW-1:FRAC_W] + 1'b1;
				f_c  = quo_s[QW][FRAC_W-1:0];
			end
			CLS_HIGH: begin
				i1_c = STOP_LAST;
				i2_c = STOP_LAST;
				f_c  = '0;
			end
			default: begin
				i1_c = STOP_FIRST;
				i2_c = STOP_FIRST;
				f_c  = '0;
			end
		endcase
		h1_c = stop_halves(i1_c);
		h2_c = stop_halves(i2_c);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_q <= pix_s[QW];
			red_q <= chan_val(h1_c[5:4], h2_c[5:4], f_c);
			grn_q <= chan_val(h1_c[3:2], h2_c[3:2], f_c);
			blu_q <= chan_val(h1_c[1:0], h2_c[1:0], f_c);
		end
	end

	assign empty       = !out_vld_q;
	assign pixel_index = pix_q;
	assign red         = red_q;
	assign green       = grn_q;
	assign blue        = blu_q;

endmodule
`default_nettype wire
